>>> rtl/core/hsb_pkg.sv
// Shared types and constants of the heightmap store and bilinear sampler.
package hsb_pkg;

  // Index fields in the command word are sized for the largest supported grid side.
  localparam int IDX_W     = 12;
  localparam int GRID_W    = 10;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'd1;

  typedef enum logic [2:0] {
    OP_GET    = 3'd0,
    OP_SET    = 3'd1,
    OP_FILL   = 3'd2,
    OP_SAMPLE = 3'd3,
    OP_MARK   = 3'd4,
    OP_TAKE   = 3'd5
  } opcode_t;

  typedef enum logic [2:0] {
    K_NONE   = 3'd0,
    K_GET    = 3'd1,
    K_SET    = 3'd2,
    K_FILL   = 3'd3,
    K_SAMPLE = 3'd4,
    K_MARK   = 3'd5,
    K_TAKE   = 3'd6
  } kind_t;

  // Classified command passed from the front end to the back end.
  typedef struct packed {
    kind_t            kind;
    logic [IDX_W-1:0] col0;
    logic [IDX_W-1:0] row0;
    logic [IDX_W-1:0] col1;
    logic [IDX_W-1:0] row1;
    logic [15:0]      tx;
    logic [15:0]      tz;
    logic [15:0]      value;
  } cmd_t;

endpackage

>>> rtl/core/hsb_if.sv
// Handshake channel interfaces for items, results and configuration writes.
interface hsb_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [10:0] x;
  logic [10:0] z;
  logic [10:0] x_end;
  logic [10:0] z_end;
  logic [15:0] data_value;
  logic [17:0] coord_u;
  logic [17:0] coord_v;
  modport source(output valid, opcode, x, z, x_end, z_end, data_value, coord_u, coord_v,
                 input ready);
  modport sink(input valid, opcode, x, z, x_end, z_end, data_value, coord_u, coord_v,
               output ready);
endinterface

interface hsb_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_value;
  logic        dirty_found;
  logic [8:0]  rect_min_x;
  logic [8:0]  rect_min_z;
  logic [8:0]  rect_max_x;
  logic [8:0]  rect_max_z;
  modport source(output valid, result_value, dirty_found, rect_min_x, rect_min_z,
                 rect_max_x, rect_max_z, input ready);
  modport sink(input valid, result_value, dirty_found, rect_min_x, rect_min_z,
               rect_max_x, rect_max_z, output ready);
endinterface

interface hsb_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [hsb_pkg::CFG_IDX_W-1:0]   index;
  logic [hsb_pkg::GRID_W-1:0]      data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

>>> rtl/core/hsb_front.sv
// Front end: grid size registers, input staging and command classification.
module hsb_front #(
  parameter int MAX_SIDE = 512
) (
  input  logic            clk,
  input  logic            rst,
  hsb_in_if.sink          item_in,
  hsb_cfg_if.sink         cfg,
  output hsb_pkg::cmd_t   push_cmd,
  output logic            push_valid,
  input  logic            push_ready
);

  localparam int CW = $clog2(MAX_SIDE);
  localparam int FW = 17 + CW;

  logic [hsb_pkg::GRID_W-1:0] grid_w;
  logic [hsb_pkg::GRID_W-1:0] grid_h;

  logic        hold_valid;
  logic [2:0]  h_op;
  logic [10:0] h_x, h_z, h_xe, h_ze;
  logic [15:0] h_val;
  logic [17:0] h_u, h_v;

  logic [CW:0]   w_side, h_side;
  logic [CW-1:0] wm, hm;
  logic [16:0]   uc, vc;
  logic [FW-1:0] fx, fz;
  logic [CW-1:0] x0, z0, x1, z1;
  hsb_pkg::cmd_t c;

  function automatic logic [CW:0] side_of(input logic [hsb_pkg::GRID_W-1:0] r);
    logic [CW:0] s;
    if (r == '0) s = (CW+1)'(1);
    else if (32'(r) > MAX_SIDE) s = (CW+1)'(MAX_SIDE);
    else s = (CW+1)'(r);
    return s;
  endfunction

  function automatic logic [CW-1:0] clamp11(input logic [10:0] v, input logic [CW-1:0] hi);
    logic [CW-1:0] r;
    if (v[10]) r = '0;
    else if (32'(v[9:0]) > 32'(hi)) r = hi;
    else r = CW'(v[9:0]);
    return r;
  endfunction

  function automatic logic in_rng(input logic [10:0] v, input logic [CW:0] side);
    return !v[10] && (32'(v[9:0]) < 32'(side));
  endfunction

  function automatic logic [16:0] clamp_q(input logic [17:0] v);
    logic [16:0] r;
    if (v[17]) r = '0;
    else if (v[16:0] > 17'd65536) r = 17'd65536;
    else r = v[16:0];
    return r;
  endfunction

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_w <= 10'd512;
      grid_h <= 10'd512;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        hsb_pkg::CFG_GRID_WIDTH:  grid_w <= cfg.data;
        hsb_pkg::CFG_GRID_HEIGHT: grid_h <= cfg.data;
        default: ;
      endcase
    end
  end

  assign item_in.ready = !hold_valid || push_ready;
  assign push_valid    = hold_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (item_in.ready) begin
      hold_valid <= item_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_in.valid && item_in.ready) begin
      h_op  <= item_in.opcode;
      h_x   <= item_in.x;
      h_z   <= item_in.z;
      h_xe  <= item_in.x_end;
      h_ze  <= item_in.z_end;
      h_val <= item_in.data_value;
      h_u   <= item_in.coord_u;
      h_v   <= item_in.coord_v;
    end
  end

  assign w_side = side_of(grid_w);
  assign h_side = side_of(grid_h);
  assign wm     = CW'(w_side - 1'b1);
  assign hm     = CW'(h_side - 1'b1);

  // Scaled coordinates: integer part picks the cell, low 16 bits are the weights.
  assign uc = clamp_q(h_u);
  assign vc = clamp_q(h_v);
  assign fx = FW'(uc) * FW'(wm);
  assign fz = FW'(vc) * FW'(hm);
  assign x0 = fx[16 +: CW];
  assign z0 = fz[16 +: CW];
  assign x1 = (x0 == wm) ? wm : x0 + 1'b1;
  assign z1 = (z0 == hm) ? hm : z0 + 1'b1;

  always_comb begin
    c = '0;
    c.kind = hsb_pkg::K_NONE;
    unique case (h_op)
      hsb_pkg::OP_GET: begin
        if (in_rng(h_x, w_side) && in_rng(h_z, h_side)) begin
          c.kind = hsb_pkg::K_GET;
          c.col0 = hsb_pkg::IDX_W'(h_x[9:0]);
          c.row0 = hsb_pkg::IDX_W'(h_z[9:0]);
        end
      end
      hsb_pkg::OP_SET: begin
        if (in_rng(h_x, w_side) && in_rng(h_z, h_side)) begin
          c.kind  = hsb_pkg::K_SET;
          c.col0  = hsb_pkg::IDX_W'(h_x[9:0]);
          c.row0  = hsb_pkg::IDX_W'(h_z[9:0]);
          c.col1  = hsb_pkg::IDX_W'(h_x[9:0]);
          c.row1  = hsb_pkg::IDX_W'(h_z[9:0]);
          c.value = h_val;
        end
      end
      hsb_pkg::OP_FILL: begin
        c.kind  = hsb_pkg::K_FILL;
        c.col1  = hsb_pkg::IDX_W'(wm);
        c.row1  = hsb_pkg::IDX_W'(hm);
        c.value = h_val;
      end
      hsb_pkg::OP_SAMPLE: begin
        c.kind = hsb_pkg::K_SAMPLE;
        c.col0 = hsb_pkg::IDX_W'(x0);
        c.row0 = hsb_pkg::IDX_W'(z0);
        c.col1 = hsb_pkg::IDX_W'(x1);
        c.row1 = hsb_pkg::IDX_W'(z1);
        c.tx   = fx[15:0];
        c.tz   = fz[15:0];
      end
      hsb_pkg::OP_MARK: begin
        c.kind = hsb_pkg::K_MARK;
        c.col0 = hsb_pkg::IDX_W'(clamp11(h_x, wm));
        c.row0 = hsb_pkg::IDX_W'(clamp11(h_z, hm));
        c.col1 = hsb_pkg::IDX_W'(clamp11(h_xe, wm));
        c.row1 = hsb_pkg::IDX_W'(clamp11(h_ze, hm));
      end
      hsb_pkg::OP_TAKE: c.kind = hsb_pkg::K_TAKE;
      default: ;
    endcase
  end

  assign push_cmd = c;

endmodule

>>> rtl/core/hsb_queue.sv
// Two-entry command queue between the front end and the back end.
module hsb_queue (
  input  logic          clk,
  input  logic          rst,
  input  hsb_pkg::cmd_t in_cmd,
  input  logic          in_valid,
  output logic          in_ready,
  output hsb_pkg::cmd_t out_cmd,
  output logic          out_valid,
  input  logic          out_ready
);

  hsb_pkg::cmd_t ent [2];
  logic          wp, rp;
  logic [1:0]    cnt;
  logic          push, pop;

  assign in_ready  = (cnt != 2'd2);
  assign out_valid = (cnt != 2'd0);
  assign out_cmd   = ent[rp];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent[wp] <= in_cmd;
  end

endmodule

>>> rtl/core/hsb_back.sv
// Back end: height memory, dirty rectangle, bilinear sequencer and result register.
module hsb_back #(
  parameter int MAX_SIDE = 512
) (
  input  logic          clk,
  input  logic          rst,
  input  hsb_pkg::cmd_t cmd,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  hsb_out_if.source     result_out
);

  localparam int CW    = $clog2(MAX_SIDE);
  localparam int DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam int LAST  = DEPTH - 1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_GET  = 4'b0010,
    S_FILL = 4'b0100,
    S_SAMP = 4'b1000
  } state_t;

  state_t        state;
  logic [2:0]    ph;
  logic [AW-1:0] fill_idx;
  hsb_pkg::cmd_t cur;
  logic          pop;
  logic          fill_last;

  logic [15:0]   mem [DEPTH];
  logic [15:0]   rdata;
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [15:0]   mem_wd;

  logic [31:0]   pr, row;
  logic [48:0]   acc, p2, sum;
  logic [16:0]   ax, az, wsel, zsel;
  logic [32:0]   m1;
  logic [48:0]   m2;

  logic          d_pend;
  logic [CW-1:0] d_minc, d_minr, d_maxc, d_maxr;
  logic          mk_en;
  logic [CW-1:0] mk_a, mk_b, mk_c, mk_d;

  logic          load;
  logic [31:0]   r_val;
  logic          r_found;
  logic [8:0]    r_minx, r_minz, r_maxx, r_maxz;
  logic          o_valid;

  function automatic logic [AW-1:0] addr_of(input logic [hsb_pkg::IDX_W-1:0] col,
                                            input logic [hsb_pkg::IDX_W-1:0] rw);
    return AW'(rw[CW-1:0]) * AW'(MAX_SIDE) + AW'(col[CW-1:0]);
  endfunction

  assign cmd_ready = (state == S_IDLE) && (!o_valid || result_out.ready);
  assign pop       = cmd_valid && cmd_ready;
  assign fill_last = (fill_idx == AW'(LAST));

  // Single-port memory access: one read or one write per cycle.
  always_comb begin
    mem_we   = 1'b0;
    mem_addr = fill_idx;
    mem_wd   = cur.value;
    unique case (state)
      S_IDLE: begin
        mem_addr = addr_of(cmd.col0, cmd.row0);
        mem_we   = pop && (cmd.kind == hsb_pkg::K_SET);
        mem_wd   = cmd.value;
      end
      S_FILL: mem_we = 1'b1;
      S_SAMP: begin
        unique case (ph[1:0])
          2'd0: mem_addr = addr_of(cur.col0, cur.row0);
          2'd1: mem_addr = addr_of(cur.col1, cur.row0);
          2'd2: mem_addr = addr_of(cur.col0, cur.row1);
          default: mem_addr = addr_of(cur.col1, cur.row1);
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wd;
    rdata <= mem[mem_addr];
  end

  // Each row pair is blended across x first, then the two rows are blended across z.
  assign ax   = 17'h10000 - {1'b0, cur.tx};
  assign az   = 17'h10000 - {1'b0, cur.tz};
  assign wsel = (ph == 3'd1 || ph == 3'd3) ? ax : {1'b0, cur.tx};
  assign zsel = (ph == 3'd4) ? az : {1'b0, cur.tz};
  assign m1   = 33'(rdata) * 33'(wsel);
  assign m2   = 49'(row) * 49'(zsel);
  assign sum  = acc + p2 + 49'd32768;

  always_ff @(posedge clk) begin
    if (state == S_SAMP) begin
      pr <= m1[31:0];
      unique case (ph)
        3'd2: row <= pr;
        3'd3: row <= row + pr;
        3'd4: begin
          acc <= m2;
          row <= pr;
        end
        3'd5: row <= row + pr;
        3'd6: p2 <= m2;
        default: ;
      endcase
    end
    if (pop) cur <= cmd;
  end

  always_comb begin
    mk_en = 1'b0;
    mk_a  = cmd.col0[CW-1:0];
    mk_b  = cmd.row0[CW-1:0];
    mk_c  = cmd.col1[CW-1:0];
    mk_d  = cmd.row1[CW-1:0];
    if (state == S_IDLE) begin
      mk_en = pop && (cmd.kind == hsb_pkg::K_SET || cmd.kind == hsb_pkg::K_MARK);
    end else if (state == S_FILL) begin
      mk_en = fill_last;
      mk_a  = cur.col0[CW-1:0];
      mk_b  = cur.row0[CW-1:0];
      mk_c  = cur.col1[CW-1:0];
      mk_d  = cur.row1[CW-1:0];
    end
  end

  always_comb begin
    load    = 1'b0;
    r_val   = '0;
    r_found = 1'b0;
    r_minx  = '0;
    r_minz  = '0;
    r_maxx  = '0;
    r_maxz  = '0;
    unique case (state)
      S_IDLE: begin
        if (pop) begin
          load = !(cmd.kind == hsb_pkg::K_GET || cmd.kind == hsb_pkg::K_FILL ||
                   cmd.kind == hsb_pkg::K_SAMPLE);
          if (cmd.kind == hsb_pkg::K_TAKE && d_pend) begin
            r_found = 1'b1;
            r_minx  = 9'(d_minc);
            r_minz  = 9'(d_minr);
            r_maxx  = 9'(d_maxc);
            r_maxz  = 9'(d_maxr);
          end
        end
      end
      S_GET: begin
        load  = 1'b1;
        r_val = {16'd0, rdata};
      end
      S_FILL: load = fill_last;
      S_SAMP: begin
        load  = (ph == 3'd7);
        r_val = sum[47:16];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      ph       <= 3'd0;
      fill_idx <= '0;
      o_valid  <= 1'b0;
      d_pend   <= 1'b0;
      d_minc   <= '0;
      d_minr   <= '0;
      d_maxc   <= '0;
      d_maxr   <= '0;
    end else begin
      o_valid <= load || (o_valid && !result_out.ready);
      if (mk_en) begin
        d_pend <= 1'b1;
        if (!d_pend || mk_a < d_minc) d_minc <= mk_a;
        if (!d_pend || mk_b < d_minr) d_minr <= mk_b;
        if (!d_pend || mk_c > d_maxc) d_maxc <= mk_c;
        if (!d_pend || mk_d > d_maxr) d_maxr <= mk_d;
      end
      unique case (state)
        S_IDLE: begin
          if (pop) begin
            unique case (cmd.kind)
              hsb_pkg::K_GET:    state <= S_GET;
              hsb_pkg::K_FILL: begin
                state    <= S_FILL;
                fill_idx <= '0;
              end
              hsb_pkg::K_SAMPLE: begin
                state <= S_SAMP;
                ph    <= 3'd0;
              end
              hsb_pkg::K_TAKE:   d_pend <= 1'b0;
              default: ;
            endcase
          end
        end
        S_GET: state <= S_IDLE;
        S_FILL: begin
          fill_idx <= fill_idx + 1'b1;
          if (fill_last) state <= S_IDLE;
        end
        S_SAMP: begin
          ph <= ph + 1'b1;
          if (ph == 3'd7) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_out.result_value <= r_val;
      result_out.dirty_found  <= r_found;
      result_out.rect_min_x   <= r_minx;
      result_out.rect_min_z   <= r_minz;
      result_out.rect_max_x   <= r_maxx;
      result_out.rect_max_z   <= r_maxz;
    end
  end

  assign result_out.valid = o_valid;

endmodule

>>> rtl/core/heightmap_store_bilinear_sampler.sv
// Items pass the front end staging register and the queue; the back end takes a new
// command only when idle. A sample is set by four reads of the single-port height
// memory and the two-step blend; a fill does one memory write per cycle to every entry.
// Reset (rst, synchronous) sets the grid to 512x512, clears the dirty rectangle and
// empties the queue; the height memory is not cleared and holds garbage until written.
module heightmap_store_bilinear_sampler #(
  parameter int MAX_SIDE = 512
) (
  input logic        clk,
  input logic        rst,
  hsb_in_if.sink     item_in,
  hsb_out_if.source  result_out,
  hsb_cfg_if.sink    cfg
);

  hsb_pkg::cmd_t f_cmd, q_cmd;
  logic          f_valid, f_ready;
  logic          q_valid, q_ready;

  hsb_front #(.MAX_SIDE(MAX_SIDE)) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_in    (item_in),
    .cfg        (cfg),
    .push_cmd   (f_cmd),
    .push_valid (f_valid),
    .push_ready (f_ready)
  );

  hsb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_cmd    (f_cmd),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .out_cmd   (q_cmd),
    .out_valid (q_valid),
    .out_ready (q_ready)
  );

  hsb_back #(.MAX_SIDE(MAX_SIDE)) u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd        (q_cmd),
    .cmd_valid  (q_valid),
    .cmd_ready  (q_ready),
    .result_out (result_out)
  );

endmodule

>>> sim/tb_hsb_scoreboard.sv
// Scoreboard package: predicts each result of the heightmap store and checks the block's output.
package hsb_sb_pkg;

  typedef struct {
    logic [31:0] result_value;
    logic        dirty_found;
    logic [8:0]  rect_min_x;
    logic [8:0]  rect_min_z;
    logic [8:0]  rect_max_x;
    logic [8:0]  rect_max_z;
  } hsb_result_t;

  class hsb_scoreboard;
    localparam int SIDE = 512;

    bit [15:0]   heights[SIDE*SIDE];
    bit [9:0]    reg_width;
    bit [9:0]    reg_height;
    bit          rect_pending;
    int unsigned rect_x0, rect_z0, rect_x1, rect_z1;
    hsb_result_t expected_q[$];
    int          errors;
    int          items_seen;
    int          results_seen;

    function new();
      reg_width    = 10'd512;
      reg_height   = 10'd512;
      rect_pending = 0;
      rect_x0 = 0; rect_z0 = 0; rect_x1 = 0; rect_z1 = 0;
      errors = 0;
      items_seen = 0;
      results_seen = 0;
    endfunction

    function int unsigned side_of(bit [9:0] r);
      if (r < 1) return 1;
      if (r > SIDE) return SIDE;
      return r;
    endfunction

    function int unsigned clamp_hi(longint v, int unsigned hi);
      if (v < 0) return 0;
      if (v > hi) return hi;
      return v;
    endfunction

    function void write_reg(logic [hsb_pkg::CFG_IDX_W-1:0] idx, logic [9:0] data);
      if (idx == hsb_pkg::CFG_GRID_WIDTH) reg_width = data;
      else if (idx == hsb_pkg::CFG_GRID_HEIGHT) reg_height = data;
    endfunction

    function void grow_rect(longint ax, longint az, longint bx, longint bz);
      int unsigned wm, hm, a, b, c, d;
      wm = side_of(reg_width) - 1;
      hm = side_of(reg_height) - 1;
      a = clamp_hi(ax, wm); b = clamp_hi(az, hm);
      c = clamp_hi(bx, wm); d = clamp_hi(bz, hm);
      if (!rect_pending) begin
        rect_pending = 1;
        rect_x0 = a; rect_z0 = b; rect_x1 = c; rect_z1 = d;
      end else begin
        if (a < rect_x0) rect_x0 = a;
        if (b < rect_z0) rect_z0 = b;
        if (c > rect_x1) rect_x1 = c;
        if (d > rect_z1) rect_z1 = d;
      end
    endfunction

    function logic [31:0] blend(longint u, longint v);
      int unsigned w, h, x0, z0, x1, z1;
      longint unsigned fx, fz, tx, tz, ax, az, acc;
      w = side_of(reg_width);
      h = side_of(reg_height);
      fx = longint'(clamp_hi(u, 65536)) * (w - 1);
      fz = longint'(clamp_hi(v, 65536)) * (h - 1);
      x0 = 32'(fx >> 16); z0 = 32'(fz >> 16);
      tx = fx & 16'hFFFF; tz = fz & 16'hFFFF;
      x1 = (x0 + 1 < w) ? x0 + 1 : w - 1;
      z1 = (z0 + 1 < h) ? z0 + 1 : h - 1;
      ax = 65536 - tx; az = 65536 - tz;
      acc = longint'(heights[z0*SIDE + x0]) * ax * az
          + longint'(heights[z0*SIDE + x1]) * tx * az
          + longint'(heights[z1*SIDE + x0]) * ax * tz
          + longint'(heights[z1*SIDE + x1]) * tx * tz;
      return 32'((acc + 32768) >> 16);
    endfunction

    function void note_item(logic [2:0] op, logic [10:0] x, logic [10:0] z,
                            logic [10:0] xe, logic [10:0] ze, logic [15:0] val,
                            logic [17:0] u, logic [17:0] v);
      hsb_result_t r;
      longint sx, sz, w, h;
      sx = $signed(x); sz = $signed(z);
      w = side_of(reg_width); h = side_of(reg_height);
      r = '{32'd0, 1'b0, 9'd0, 9'd0, 9'd0, 9'd0};
      items_seen++;
      case (op)
        hsb_pkg::OP_GET: begin
          if (sx >= 0 && sz >= 0 && sx < w && sz < h)
            r.result_value = 32'(heights[sz*SIDE + sx]);
        end
        hsb_pkg::OP_SET: begin
          if (sx >= 0 && sz >= 0 && sx < w && sz < h) begin
            heights[sz*SIDE + sx] = val;
            grow_rect(sx, sz, sx, sz);
          end
        end
        hsb_pkg::OP_FILL: begin
          foreach (heights[i]) heights[i] = val;
          grow_rect(0, 0, w - 1, h - 1);
        end
        hsb_pkg::OP_SAMPLE: r.result_value = blend($signed(u), $signed(v));
        hsb_pkg::OP_MARK: grow_rect(sx, sz, $signed(xe), $signed(ze));
        hsb_pkg::OP_TAKE: begin
          if (rect_pending) begin
            r.dirty_found = 1;
            r.rect_min_x = 9'(rect_x0); r.rect_min_z = 9'(rect_z0);
            r.rect_max_x = 9'(rect_x1); r.rect_max_z = 9'(rect_z1);
            rect_pending = 0;
          end
        end
        default: ;
      endcase
      expected_q.push_back(r);
    endfunction

    function void check_result(hsb_result_t got);
      hsb_result_t e;
      results_seen++;
      if (expected_q.size() == 0) begin
        $display("%0t: result beat with nothing expected (value %h)", $time, got.result_value);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (got.result_value !== e.result_value) begin
        $display("%0t: result_value expected %h got %h", $time, e.result_value,
                 got.result_value);
        errors++;
      end
      if (got.dirty_found !== e.dirty_found) begin
        $display("%0t: dirty_found expected %b got %b", $time, e.dirty_found, got.dirty_found);
        errors++;
      end
      if (got.rect_min_x !== e.rect_min_x) begin
        $display("%0t: rect_min_x expected %0d got %0d", $time, e.rect_min_x, got.rect_min_x);
        errors++;
      end
      if (got.rect_min_z !== e.rect_min_z) begin
        $display("%0t: rect_min_z expected %0d got %0d", $time, e.rect_min_z, got.rect_min_z);
        errors++;
      end
      if (got.rect_max_x !== e.rect_max_x) begin
        $display("%0t: rect_max_x expected %0d got %0d", $time, e.rect_max_x, got.rect_max_x);
        errors++;
      end
      if (got.rect_max_z !== e.rect_max_z) begin
        $display("%0t: rect_max_z expected %0d got %0d", $time, e.rect_max_z, got.rect_max_z);
        errors++;
      end
    endfunction
  endclass

endpackage

>>> sim/tb_heightmap_store_bilinear_sampler.sv
// Top-level testbench of the heightmap store with bilinear sampler.
module tb_heightmap_store_bilinear_sampler;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint CYCLE_LIMIT = 3_000_000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  bit   hold_off = 0;
  longint cycles = 0;
  int   cfg_writes = 0;

  hsb_in_if  in_ch();
  hsb_out_if out_ch();
  hsb_cfg_if cfg_ch();

  hsb_sb_pkg::hsb_scoreboard sb = new();

  heightmap_store_bilinear_sampler uut (
    .clk(clk), .rst(rst), .item_in(in_ch), .result_out(out_ch), .cfg(cfg_ch)
  );

  always #4 clk = ~clk;

  initial begin
    in_ch.valid = 0; in_ch.opcode = hsb_pkg::OP_GET; in_ch.x = 0; in_ch.z = 0;
    in_ch.x_end = 0; in_ch.z_end = 0; in_ch.data_value = 0;
    in_ch.coord_u = 0; in_ch.coord_v = 0;
    out_ch.ready = 0;
    cfg_ch.valid = 0; cfg_ch.index = hsb_pkg::CFG_GRID_WIDTH; cfg_ch.data = 0;
  end

  // Receiver: ready changes at the falling edge; the hold-off forces a long stall.
  always @(negedge clk) begin
    out_ch.ready = !hold_off && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Every beat is sampled at the rising edge.
  always @(posedge clk) begin
    hsb_sb_pkg::hsb_result_t got;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("heightmap_store_bilinear_sampler: mismatch");
      $finish;
    end else if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready) sb.write_reg(cfg_ch.index, cfg_ch.data);
      if (in_ch.valid && in_ch.ready)
        sb.note_item(in_ch.opcode, in_ch.x, in_ch.z, in_ch.x_end, in_ch.z_end,
                     in_ch.data_value, in_ch.coord_u, in_ch.coord_v);
      if (out_ch.valid && out_ch.ready) begin
        got.result_value = out_ch.result_value;
        got.dirty_found  = out_ch.dirty_found;
        got.rect_min_x   = out_ch.rect_min_x;
        got.rect_min_z   = out_ch.rect_min_z;
        got.rect_max_x   = out_ch.rect_max_x;
        got.rect_max_z   = out_ch.rect_max_z;
        sb.check_result(got);
      end
    end
  end

  task automatic send_item(logic [2:0] op, logic [10:0] x, logic [10:0] z,
                           logic [10:0] xe, logic [10:0] ze, logic [15:0] val,
                           logic [17:0] u, logic [17:0] v);
    @(negedge clk);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid = 0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_ch.opcode = op; in_ch.x = x; in_ch.z = z; in_ch.x_end = xe; in_ch.z_end = ze;
    in_ch.data_value = val; in_ch.coord_u = u; in_ch.coord_v = v;
    in_ch.valid = 1;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid = 0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [hsb_pkg::CFG_IDX_W-1:0] idx, logic [9:0] data);
    @(negedge clk);
    cfg_ch.index = idx; cfg_ch.data = data; cfg_ch.valid = 1;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 0;
    cfg_writes++;
  endtask

  task automatic set_grid(logic [9:0] w, logic [9:0] h);
    drain();
    write_reg(hsb_pkg::CFG_GRID_WIDTH, w);
    write_reg(hsb_pkg::CFG_GRID_HEIGHT, h);
  endtask

  // Index mostly inside the grid in use, sometimes anywhere in the signed field.
  function automatic logic [10:0] pick_idx(int unsigned side);
    if ($urandom_range(0, 99) < 80) return 11'($urandom_range(0, side - 1));
    return 11'($urandom);
  endfunction

  function automatic logic [17:0] pick_coord();
    if ($urandom_range(0, 99) < 70) return 18'($urandom_range(0, 65536));
    return 18'($urandom);
  endfunction

  task automatic random_items(int n);
    int unsigned w, h, pick;
    logic [2:0] op;
    w = sb.side_of(sb.reg_width);
    h = sb.side_of(sb.reg_height);
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) op = hsb_pkg::OP_SET;
      else if (pick < 50) op = hsb_pkg::OP_GET;
      else if (pick < 75) op = hsb_pkg::OP_SAMPLE;
      else if (pick < 85) op = hsb_pkg::OP_MARK;
      else if (pick < 96) op = hsb_pkg::OP_TAKE;
      else op = 3'(hsb_pkg::OP_TAKE) + 3'($urandom_range(1, 2));
      send_item(op, pick_idx(w), pick_idx(h), pick_idx(w), pick_idx(h),
                16'($urandom), pick_coord(), pick_coord());
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed part on the full grid; the fill makes every entry readable.
    send_idle_pct = 0; recv_idle_pct = 0;
    set_grid(10'd512, 10'd512);
    send_item(hsb_pkg::OP_FILL, 0, 0, 0, 0, 16'hA5A5, 0, 0);
    send_item(hsb_pkg::OP_TAKE, 0, 0, 0, 0, 0, 0, 0);
    send_item(hsb_pkg::OP_TAKE, 0, 0, 0, 0, 0, 0, 0);
    send_item(hsb_pkg::OP_SET, 11'd0, 11'd0, 0, 0, 16'h0000, 0, 0);
    send_item(hsb_pkg::OP_SET, 11'd511, 11'd511, 0, 0, 16'hFFFF, 0, 0);
    send_item(hsb_pkg::OP_SET, 11'd511, 11'd0, 0, 0, 16'hFFFF, 0, 0);
    send_item(hsb_pkg::OP_SET, 11'h400, 11'd3, 0, 0, 16'h1234, 0, 0);
    send_item(hsb_pkg::OP_SET, 11'd512, 11'd3, 0, 0, 16'h1234, 0, 0);
    send_item(hsb_pkg::OP_GET, 11'd511, 11'd511, 0, 0, 0, 0, 0);
    send_item(hsb_pkg::OP_GET, 11'd0, 11'd0, 0, 0, 0, 0, 0);
    send_item(hsb_pkg::OP_GET, 11'h7FF, 11'd0, 0, 0, 0, 0, 0);
    send_item(hsb_pkg::OP_GET, 11'd1023, 11'd1023, 0, 0, 0, 0, 0);
    send_item(hsb_pkg::OP_SAMPLE, 0, 0, 0, 0, 0, 18'd0, 18'd0);
    send_item(hsb_pkg::OP_SAMPLE, 0, 0, 0, 0, 0, 18'd65536, 18'd65536);
    send_item(hsb_pkg::OP_SAMPLE, 0, 0, 0, 0, 0, 18'h20000, 18'h1FFFF);
    send_item(hsb_pkg::OP_SAMPLE, 0, 0, 0, 0, 0, 18'd32768, 18'd65535);
    send_item(hsb_pkg::OP_TAKE, 0, 0, 0, 0, 0, 0, 0);
    // An inverted region is taken as is when nothing is pending.
    send_item(hsb_pkg::OP_MARK, 11'd300, 11'd200, 11'd10, 11'd20, 0, 0, 0);
    send_item(hsb_pkg::OP_MARK, 11'h400, 11'd250, 11'd1023, 11'h7FF, 0, 0, 0);
    send_item(hsb_pkg::OP_TAKE, 0, 0, 0, 0, 0, 0, 0);
    send_item(3'(hsb_pkg::OP_TAKE) + 3'd1, 11'h7FF, 11'h7FF, 11'h7FF, 11'h7FF, 16'hFFFF,
              18'h3FFFF, 18'h3FFFF);
    send_item(3'(hsb_pkg::OP_TAKE) + 3'd2, 0, 0, 0, 0, 0, 0, 0);
    send_item(hsb_pkg::OP_TAKE, 0, 0, 0, 0, 0, 0, 0);

    // Sender idles seldom, receiver often.
    send_idle_pct = 19; recv_idle_pct = 81;
    set_grid(10'd1, 10'd1);
    random_items(270);
    set_grid(10'd0, 10'd1023);
    random_items(270);

    // Receiver idles seldom; a long stall fills the block and backs up the input.
    send_idle_pct = 81; recv_idle_pct = 19;
    set_grid(10'd2, 10'd3);
    fork
      begin
        hold_off = 1;
        repeat (400) @(posedge clk);
        hold_off = 0;
      end
    join_none
    send_idle_pct = 0;
    random_items(100);
    send_idle_pct = 81;
    random_items(170);
    set_grid(10'($urandom_range(1, 512)), 10'($urandom_range(1, 512)));
    random_items(270);

    // No idling on either side; a second fill with the grid at its widest.
    send_idle_pct = 0; recv_idle_pct = 0;
    set_grid(10'd512, 10'd7);
    send_item(hsb_pkg::OP_FILL, 0, 0, 0, 0, 16'($urandom), 0, 0);
    random_items(270);
    set_grid(10'd37, 10'd512);
    random_items(270);

    drain();
    repeat (30) @(posedge clk);
    $display("covered %0d items, %0d results, %0d register writes over seven grid sizes",
             sb.items_seen, sb.results_seen, cfg_writes);
    $display("including fills, edge and out-of-range indexes, clamped coordinates and stalls");
    if (sb.errors == 0 && sb.results_seen == sb.items_seen && sb.expected_q.size() == 0)
      $display("heightmap_store_bilinear_sampler: match");
    else
      $display("heightmap_store_bilinear_sampler: mismatch");
    $finish;
  end
endmodule
